// ----- hw/rtl/tone_sequence_player_core_defines.svh -----
// ----------------------------------------------------------------------------
// Tone sequence player assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_CORE_DEFINES_SVH
`define TONE_SEQUENCE_PLAYER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tone sequence player check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tone sequence player check failed");

`endif

// ----- hw/rtl/tsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone sequence player package
// Command codes, register indexes, step record and step finishing helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_WRITE,
		CMD_PLAY,
		CMD_STOP
	} cmd_t;

	localparam logic [1:0] CFG_GUARD_MIN_DELTA = 2'd0;
	localparam logic [1:0] CFG_GUARD_PERCENT   = 2'd1;
	localparam logic [1:0] CFG_GUARD_MS        = 2'd2;

	localparam logic [15:0] RST_GUARD_MIN_DELTA = 16'd100;
	localparam logic [6:0]  RST_GUARD_PERCENT   = 7'd10;
	localparam logic [15:0] RST_GUARD_MS        = 16'd20;

	localparam logic [6:0] GUARD_SCALE = 7'd100;

	typedef struct packed {
		logic [15:0] hz;
		logic [15:0] dur;
		logic [15:0] pause;
	} step_t;

	typedef struct packed {
		logic [15:0] sounding;
		logic [15:0] remaining;
		logic [15:0] pend;
	} fin_t;

	// zero duration with a pause goes silent and runs the pause at once
	function automatic fin_t finish_step(step_t s);
		fin_t f;
		f.sounding  = s.hz;
		f.remaining = s.dur;
		f.pend      = s.pause;
		if (s.pause != 16'd0 && s.dur == 16'd0) begin
			f.sounding  = '0;
			f.remaining = s.pause;
			f.pend      = '0;
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tone_sequence_player_core.sv -----
// ----------------------------------------------------------------------------
// Tone sequence player core
// Results: an item that needs no table read is registered in the result register in the cycle after
// it is taken; a step load first reads the step through the registered table read port.
// Throughput: one item per cycle, stalled while a result waits or a step load finishes.
// Reset clears control state and restores register defaults; table undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_sequence_player_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [5:0]  entry_index,
	input  wire logic [15:0] step_hz,
	input  wire logic [15:0] step_duration_ms,
	input  wire logic [15:0] step_pause_ms,
	input  wire logic [6:0]  seq_length,
	input  wire logic        loop_mode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      tone_hz,
	output logic             is_playing,
	output logic [6:0]       next_step
);
	import tsp_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = (AW > 7) ? AW : 7;
	localparam logic [6:0] DEPTH_SAT = (TABLE_DEPTH > 127) ? 7'd127 : 7'(TABLE_DEPTH);

	// configuration
	logic [15:0] guard_min_q;
	logic [6:0]  guard_pct_q;
	logic [15:0] guard_ms_q;

	// playback state
	logic        playing_q,  playing_d;
	logic        looping_q,  looping_d;
	logic [6:0]  act_len_q,  act_len_d;
	logic [6:0]  step_idx_q, step_idx_d;
	logic        in_pause_q, in_pause_d;
	logic [15:0] pend_q,     pend_d;
	logic        guard_q,    guard_d;
	step_t       held_q,     held_d;
	logic [15:0] remain_q,   remain_d;
	logic [15:0] sound_q,    sound_d;

	logic        load_s2;
	logic        need_read;
	logic        done;
	logic        do_load;
	logic        in_accept;
	cmd_t        cmd_c;

	step_t       mem [TABLE_DEPTH];
	step_t       rd_q;
	logic        mem_we;
	logic [IW-1:0] wr_wide;
	logic [IW-1:0] rd_wide;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic        entry_ok;

	logic [15:0] rem_dec;
	logic [6:0]  len_sat;
	logic [15:0] delta;
	logic [15:0] top;
	logic [22:0] prod_delta;
	logic [22:0] prod_top;
	logic        guard_hit;
	fin_t        fin_mem;
	fin_t        fin_held;

	logic        out_valid_q;
	logic [15:0] tone_q;
	logic        play_q;
	logic [6:0]  next_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !load_s2 && (!out_valid_q || out_ready);
	assign in_accept = in_valid && in_ready;
	assign cmd_c     = cmd_t'(cmd);

	assign wr_wide  = IW'(entry_index);
	assign wr_addr  = wr_wide[AW-1:0];
	assign rd_addr  = rd_wide[AW-1:0];
	assign entry_ok = int'(entry_index) < TABLE_DEPTH;

	assign rem_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : '0;
	assign len_sat = (seq_length > DEPTH_SAT) ? DEPTH_SAT : seq_length;

	// retune guard on the freshly read step
	assign delta      = (sound_q > rd_q.hz) ? sound_q - rd_q.hz : rd_q.hz - sound_q;
	assign top        = (sound_q > rd_q.hz) ? sound_q : rd_q.hz;
	assign prod_delta = 23'(delta) * 23'(GUARD_SCALE);
	assign prod_top   = 23'(top) * 23'(guard_pct_q);
	assign guard_hit  = sound_q != 16'd0 && rd_q.hz != 16'd0 && delta >= guard_min_q
		&& prod_delta >= prod_top;

	assign fin_mem  = finish_step(rd_q);
	assign fin_held = finish_step(held_q);

	always_comb begin
		playing_d  = playing_q;
		looping_d  = looping_q;
		act_len_d  = act_len_q;
		step_idx_d = step_idx_q;
		in_pause_d = in_pause_q;
		pend_d     = pend_q;
		guard_d    = guard_q;
		held_d     = held_q;
		remain_d   = remain_q;
		sound_d    = sound_q;
		mem_we     = 1'b0;
		need_read  = 1'b0;
		do_load    = 1'b0;
		done       = 1'b0;

		if (load_s2) begin
			done   = 1'b1;
			held_d = rd_q;
			if (guard_hit) begin
				sound_d    = '0;
				guard_d    = 1'b1;
				remain_d   = guard_ms_q;
				in_pause_d = 1'b1;
			end else begin
				guard_d    = 1'b0;
				step_idx_d = 7'(step_idx_q + 7'd1);
				sound_d    = fin_mem.sounding;
				remain_d   = fin_mem.remaining;
				pend_d     = fin_mem.pend;
			end
		end else if (in_accept) begin
			case (cmd_c)
				CMD_TICK: begin
					if (playing_q) begin
						remain_d = rem_dec;
						if (rem_dec == 16'd0) begin
							if (in_pause_q) begin
								in_pause_d = 1'b0;
								do_load    = 1'b1;
							end else if (pend_q != 16'd0) begin
								sound_d    = '0;
								remain_d   = pend_q;
								pend_d     = '0;
								in_pause_d = 1'b1;
							end else begin
								do_load = 1'b1;
							end
						end
					end
				end
				CMD_WRITE: begin
					mem_we = entry_ok;
				end
				CMD_PLAY: begin
					act_len_d  = len_sat;
					looping_d  = loop_mode;
					step_idx_d = '0;
					playing_d  = 1'b1;
					in_pause_d = 1'b0;
					pend_d     = '0;
					guard_d    = 1'b0;
					remain_d   = '0;
					do_load    = 1'b1;
				end
				CMD_STOP: begin
					if (playing_q) begin
						sound_d    = '0;
						playing_d  = 1'b0;
						step_idx_d = '0;
						pend_d     = '0;
						in_pause_d = 1'b0;
						guard_d    = 1'b0;
					end
				end
				default: ;
			endcase

			if (do_load) begin
				if (act_len_d == 7'd0 || (step_idx_d >= act_len_d && !looping_d)) begin
					sound_d    = '0;
					playing_d  = 1'b0;
					step_idx_d = '0;
					pend_d     = '0;
					in_pause_d = 1'b0;
					guard_d    = 1'b0;
				end else begin
					if (step_idx_d >= act_len_d) begin
						step_idx_d = '0;
					end
					if (guard_q && guard_d) begin
						guard_d    = 1'b0;
						step_idx_d = 7'(step_idx_d + 7'd1);
						sound_d    = fin_held.sounding;
						remain_d   = fin_held.remaining;
						pend_d     = fin_held.pend;
					end else begin
						need_read = 1'b1;
					end
				end
			end
			done = !need_read;
		end
		rd_wide = IW'(step_idx_d);
	end

	// step table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= '{hz: step_hz, dur: step_duration_ms, pause: step_pause_ms};
		end
		if (need_read) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_min_q <= RST_GUARD_MIN_DELTA;
			guard_pct_q <= RST_GUARD_PERCENT;
			guard_ms_q  <= RST_GUARD_MS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GUARD_MIN_DELTA: guard_min_q <= cfg_data;
				CFG_GUARD_PERCENT:   guard_pct_q <= cfg_data[6:0];
				CFG_GUARD_MS:        guard_ms_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q  <= 1'b0;
			looping_q  <= 1'b0;
			act_len_q  <= '0;
			step_idx_q <= '0;
			in_pause_q <= 1'b0;
			pend_q     <= '0;
			guard_q    <= 1'b0;
			held_q     <= '0;
			remain_q   <= '0;
			sound_q    <= '0;
			load_s2    <= 1'b0;
		end else begin
			playing_q  <= playing_d;
			looping_q  <= looping_d;
			act_len_q  <= act_len_d;
			step_idx_q <= step_idx_d;
			in_pause_q <= in_pause_d;
			pend_q     <= pend_d;
			guard_q    <= guard_d;
			held_q     <= held_d;
			remain_q   <= remain_d;
			sound_q    <= sound_d;
			load_s2    <= need_read;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			tone_q <= sound_d;
			play_q <= playing_d;
			next_q <= step_idx_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign tone_hz    = tone_q;
	assign is_playing = play_q;
	assign next_step  = next_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tsp_checker.sv -----
// ----------------------------------------------------------------------------
// Tone sequence player port checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tone_sequence_player_core_defines.svh"

module tsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] tone_hz,
	input wire logic        is_playing,
	input wire logic [6:0]  next_step
);
	import tsp_pkg::*;

	`TSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tone_hz))
	`TSP_ASSERT_IMPL(a_idle_silent, out_valid && !is_playing, tone_hz == 16'd0 && next_step == 7'd0)
	`TSP_ASSERT_IMPL(a_no_overrun, out_valid && !out_ready, !in_ready)
	`TSP_ASSERT_NEXT(a_stop_result, in_valid && in_ready && cmd == CMD_STOP, out_valid && !is_playing)
	`TSP_ASSERT_NEXT(a_write_result, in_valid && in_ready && cmd == CMD_WRITE, out_valid)

endmodule

bind tone_sequence_player_core tsp_checker u_tsp_checker (.*);

`default_nettype wire
